FILE: hdl/mesw_pkg.sv
// constants and register codes for the max end sum window block
package mesw_pkg;
    localparam int MAX_CARDS  = 1024;
    localparam int RING_AW    = $clog2(MAX_CARDS);
    localparam int POINT_BITS = 16;
    localparam int CNT_W      = 11;
    localparam int SUM_W      = 27;
    localparam int OUT_W      = 26;
    localparam int IN_TDATA_W  = ((POINT_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CARD_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAKE_COUNT = 2'd1;

    localparam logic [CNT_W-1:0] CARD_MAX = CNT_W'(MAX_CARDS);
endpackage

FILE: hdl/max_end_sum_window_core.sv
// max end sum window core: ring buffer of row values and sliding window minimum
//
// usage: set card_count and take_count through the cfg channel (index 0 and 1)
// while no row item is in flight. then stream one row value per s_ beat on
// s_tdata. on the last value of each row one result beat comes out on m_,
// holding the largest sum of take_count values from the two ends of the row.
// after the edge that accepts the last value, the result passes the ring read
// stage, the holding stage and the output register before m_tvalid rises.
// throughput: one value per cycle while s_tready is high; each value costs one
// ring write and one registered ring read (the value leaving the window).
// a stalled m_ side is covered by the output register plus one holding stage,
// so inputs keep flowing until both hold a result; then s_tready drops.
// reset: aresetn (synchronous, active low) clears the sums, the count, the
// pipeline valids and sets both counts to 1. the ring needs no clearing:
// every read that is used hits an entry already written in the current row.
module max_end_sum_window_core
    import mesw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CNT_W-1:0]       cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] point
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [25:0] best_sum, rest zero
);

    logic [CNT_W-1:0] card_reg, take_reg;
    logic [CNT_W-1:0] seen_reg, seen_next;

    // stage 1 (after ring read)
    logic                  s1_valid_reg;
    logic [POINT_BITS-1:0] s1_point_reg;
    logic                  s1_fill_reg, s1_fill_done_reg, s1_slide_reg, s1_last_reg;
    logic [POINT_BITS-1:0] rd_data_reg;

    logic [SUM_W-1:0] total_reg, total_next;
    logic [SUM_W-1:0] window_reg, window_next;
    logic [SUM_W-1:0] least_reg, least_next;

    // holding stage and output register
    logic             fin_valid_reg;
    logic [SUM_W-1:0] fin_total_reg, fin_least_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [SUM_W-1:0] diff;

    logic [POINT_BITS-1:0] ring_mem [MAX_CARDS];

    logic             out_free, adv, accept;
    logic [CNT_W-1:0] n_clamp, k_clamp, w_len;
    logic [CNT_W:0]   seen_inc;
    logic             fill, fill_done, slide, last;
    logic [CNT_W-1:0] rd_idx;
    logic [SUM_W-1:0] v_ext, rd_ext;

    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || m_tready;
    assign adv      = !(fin_valid_reg && !out_free);
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // row geometry from the current counts
    always_comb begin
        n_clamp = card_reg;
        if (n_clamp == '0) begin
            n_clamp = CNT_W'(1);
        end else if (n_clamp > CARD_MAX) begin
            n_clamp = CARD_MAX;
        end
        k_clamp = (take_reg > n_clamp) ? n_clamp : take_reg;
        w_len   = n_clamp - k_clamp;

        seen_inc  = {1'b0, seen_reg} + (CNT_W+1)'(1);
        fill      = (w_len != '0) && (seen_reg < w_len);
        fill_done = (w_len != '0) && (seen_inc == {1'b0, w_len});
        slide     = (w_len != '0) && (seen_reg >= w_len);
        last      = seen_inc >= {1'b0, n_clamp};
        rd_idx    = seen_reg - w_len;
        seen_next = last ? '0 : seen_inc[CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            card_reg <= CNT_W'(1);
            take_reg <= CNT_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CARD_COUNT: card_reg <= cfg_data;
                CFG_TAKE_COUNT: take_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ring: write the new value, read the one leaving the window
    always_ff @(posedge aclk) begin
        if (accept) begin
            ring_mem[seen_reg[RING_AW-1:0]] <= s_tdata[POINT_BITS-1:0];
            rd_data_reg <= ring_mem[rd_idx[RING_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= accept;
            if (accept) begin
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_point_reg     <= s_tdata[POINT_BITS-1:0];
            s1_fill_reg      <= fill;
            s1_fill_done_reg <= fill_done;
            s1_slide_reg     <= slide;
            s1_last_reg      <= last;
        end
    end

    // running sums
    always_comb begin
        v_ext       = SUM_W'(s1_point_reg);
        rd_ext      = SUM_W'(rd_data_reg);
        total_next  = total_reg + v_ext;
        window_next = window_reg;
        least_next  = least_reg;
        if (s1_fill_reg) begin
            window_next = window_reg + v_ext;
            if (s1_fill_done_reg) begin
                least_next = window_next;
            end
        end else if (s1_slide_reg) begin
            window_next = window_reg + v_ext - rd_ext;
            if (window_next < least_reg) begin
                least_next = window_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= '0;
            window_reg <= '0;
            least_reg  <= '0;
        end else if (adv && s1_valid_reg) begin
            if (s1_last_reg) begin
                total_reg  <= '0;
                window_reg <= '0;
                least_reg  <= '0;
            end else begin
                total_reg  <= total_next;
                window_reg <= window_next;
                least_reg  <= least_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (adv) begin
            fin_valid_reg <= s1_valid_reg && s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s1_valid_reg && s1_last_reg) begin
            fin_total_reg <= total_next;
            fin_least_reg <= least_next;
        end
    end

    assign diff = fin_total_reg - fin_least_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && fin_valid_reg) begin
            out_data_reg <= diff[OUT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule
